/* src/dsd_pkg.sv */
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants of the deadband sample downsampler
// Holds the beat structs of both channels, the register map, the decision
// codes and the ring geometry.
// ----------------------------------------------------------------------------
package dsd_pkg;

    // Ring geometry. The slot fields of a result beat follow from the depth.
    localparam int RING_DEPTH = 512;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Register reset values.
    localparam logic [31:0] VALUE_THRESHOLD_RST = 32'd100;
    localparam logic [31:0] TIME_LIMIT_RST      = 32'd900;

    // Register map: index taken from paddr[2].
    localparam int         PADDR_W             = 3;
    localparam logic [0:0] REG_VALUE_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_TIME_LIMIT      = 1'b1;

    // Decision for one input sample.
    localparam logic [1:0] ACT_HOLD      = 2'd0;
    localparam logic [1:0] ACT_KEEP_NEW  = 2'd1;
    localparam logic [1:0] ACT_KEEP_BOTH = 2'd2;

    typedef struct packed {
        logic [30:0]        sample_time;
        logic signed [31:0] sample_value;
    } meter_sample_t;

    typedef struct packed {
        logic [30:0]        kept_time;
        logic signed [31:0] kept_value;
        logic [PTR_W-1:0]   slot_index;
        logic [PTR_W-1:0]   oldest_index;
        logic               last_of_run;
    } kept_t;

endpackage

/* src/dsd_classify.sv */
// ----------------------------------------------------------------------------
// dsd_classify: keep or hold decision for one sample
// Compares the sample against the last kept one by absolute value and time
// difference, both at full width, and picks the action.
// ----------------------------------------------------------------------------
module dsd_classify
    import dsd_pkg::*;
(
    input  logic          kept_valid,
    input  logic          pend_valid,
    input  meter_sample_t kept,
    input  meter_sample_t sample,
    input  logic [31:0]   value_threshold,
    input  logic [31:0]   time_limit,
    output logic [1:0]    action
);

    logic signed [32:0] value_diff;
    logic [31:0]        value_mag;
    logic [30:0]        time_mag;
    logic               value_over;
    logic               time_over;

    // Signed difference on 33 bits cannot overflow; its magnitude fits 32 bits.
    assign value_diff = {kept.sample_value[31], kept.sample_value}
                      - {sample.sample_value[31], sample.sample_value};
    assign value_mag  = value_diff[32] ? 32'(-value_diff) : 32'(value_diff);
    assign value_over = value_mag > value_threshold;

    // Time may run backwards, so the absolute difference is used.
    assign time_mag  = (kept.sample_time > sample.sample_time)
                     ? kept.sample_time - sample.sample_time
                     : sample.sample_time - kept.sample_time;
    assign time_over = {1'b0, time_mag} > time_limit;

    // The first sample is always kept; a value step flushes the pending one.
    always_comb
    begin
        priority if (!kept_valid)
        begin
            action = ACT_KEEP_NEW;
        end
        else if (value_over)
        begin
            action = pend_valid ? ACT_KEEP_BOTH : ACT_KEEP_NEW;
        end
        else if (time_over)
        begin
            action = ACT_KEEP_NEW;
        end
        else
        begin
            action = ACT_HOLD;
        end
    end

endmodule

/* src/dsd_ring.sv */
// ----------------------------------------------------------------------------
// dsd_ring: write and oldest pointers of the sample ring
// Gives the slot of the next write and the oldest slot after that write, and
// advances both when a sample is emitted.
// ----------------------------------------------------------------------------
module dsd_ring
    import dsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    output logic [PTR_W-1:0] slot,
    output logic [PTR_W-1:0] oldest_after
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0] write_ptr_reg;
    logic [PTR_W-1:0] write_ptr_next;
    logic [PTR_W-1:0] oldest_ptr_reg;
    logic [PTR_W-1:0] oldest_ptr_next;

    // Advance by one with wrap; the oldest pointer is pushed on overrun.
    always_comb
    begin
        write_ptr_next  = (write_ptr_reg == LAST_SLOT) ? '0 : write_ptr_reg + 1'b1;
        oldest_ptr_next = oldest_ptr_reg;
        if (write_ptr_next == oldest_ptr_reg)
        begin
            oldest_ptr_next = (oldest_ptr_reg == LAST_SLOT) ? '0 : oldest_ptr_reg + 1'b1;
        end
    end

    assign slot         = write_ptr_reg;
    assign oldest_after = oldest_ptr_next;

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg  <= '0;
            oldest_ptr_reg <= '0;
        end
        else if (advance)
        begin
            write_ptr_reg  <= write_ptr_next;
            oldest_ptr_reg <= oldest_ptr_next;
        end
    end

endmodule

/* src/deadband_sample_downsampler.sv */
// ----------------------------------------------------------------------------
// deadband_sample_downsampler: deadband compression with a time heartbeat
// Samples enter on in_beat (valid/ready). Each one is kept, held as the
// pending sample, or, on a value step, flushes the pending sample ahead of
// itself. Kept samples leave on out_beat with their ring slot, the oldest
// slot after the write and a flag on the last beat of each input.
//
// An accepted sample waits in the input register; its first result beat is
// then registered in the output register once that register is free, which
// raises out_valid. One sample is taken per cycle while in_ready is high; a
// sample that emits two beats holds the input register until its second
// beat is registered, as the single output register takes at most one beat
// per cycle. A held sample produces no beat and never waits for the output side.
// When the receiver stalls, the output beat holds, the input register fills
// and in_ready falls; nothing is dropped. Reset clears the last kept and
// pending samples, both ring pointers and restores value_threshold to 100
// and time_limit to 900. The first sample after reset is always kept. The
// user must write value_threshold (0x0) and time_limit (0x4) through the
// APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module deadband_sample_downsampler
    import dsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  meter_sample_t      in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output kept_t              out_beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] value_threshold_reg;
    logic [31:0] time_limit_reg;

    logic          s1_valid_reg;
    meter_sample_t s1_beat_reg;
    logic          phase_reg;

    logic          kept_valid_reg;
    meter_sample_t kept_reg;
    logic          pend_valid_reg;
    meter_sample_t pend_reg;

    logic        out_valid_reg;
    kept_t       out_beat_reg;
    kept_t       out_beat_next;

    logic [1:0]       action;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] oldest_after;
    logic             out_free;
    logic             emit;
    logic             step;
    logic             s1_done;
    logic             cfg_write;

    // Configuration port: always ready, write on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_VALUE_THRESHOLD: prdata = value_threshold_reg;
            REG_TIME_LIMIT:      prdata = time_limit_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_threshold_reg <= VALUE_THRESHOLD_RST;
            time_limit_reg      <= TIME_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_VALUE_THRESHOLD: value_threshold_reg <= pwdata;
                REG_TIME_LIMIT:      time_limit_reg      <= pwdata;
                default:             ;
            endcase
        end
    end

    // Decision on the registered sample.
    dsd_classify u_classify
    (
        .kept_valid      (kept_valid_reg),
        .pend_valid      (pend_valid_reg),
        .kept            (kept_reg),
        .sample          (s1_beat_reg),
        .value_threshold (value_threshold_reg),
        .time_limit      (time_limit_reg),
        .action          (action)
    );

    // Ring pointers advance once for every emitted beat.
    dsd_ring u_ring
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (emit),
        .slot         (slot),
        .oldest_after (oldest_after)
    );

    // A step emits a beat unless the sample is held; the first beat of a
    // double emission leaves the sample in place for a second step.
    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && (out_free || (action == ACT_HOLD && !phase_reg));
    assign emit     = step && (phase_reg || action != ACT_HOLD);
    assign s1_done  = step && (phase_reg || action != ACT_KEEP_BOTH);
    assign in_ready = !s1_valid_reg || s1_done;

    // Result beat: the pending sample first, then the new one.
    always_comb
    begin
        out_beat_next.slot_index   = slot;
        out_beat_next.oldest_index = oldest_after;
        if (!phase_reg && action == ACT_KEEP_BOTH)
        begin
            out_beat_next.kept_time   = pend_reg.sample_time;
            out_beat_next.kept_value  = pend_reg.sample_value;
            out_beat_next.last_of_run = 1'b0;
        end
        else
        begin
            out_beat_next.kept_time   = s1_beat_reg.sample_time;
            out_beat_next.kept_value  = s1_beat_reg.sample_value;
            out_beat_next.last_of_run = 1'b1;
        end
    end

    // Control registers: input stage, phase, kept and pending flags, output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            kept_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (step)
            begin
                phase_reg <= !phase_reg && action == ACT_KEEP_BOTH;
                if (phase_reg || action != ACT_KEEP_BOTH)
                begin
                    kept_valid_reg <= 1'b1;
                    pend_valid_reg <= !phase_reg && action == ACT_HOLD;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_beat_reg <= in_beat;
        end
        if (s1_done)
        begin
            if (!phase_reg && action == ACT_HOLD)
            begin
                pend_reg <= s1_beat_reg;
            end
            else
            begin
                kept_reg <= s1_beat_reg;
            end
        end
        if (emit)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // The second step of a double emission always has its sample in place.
    a_phase_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> s1_valid_reg)
        else $error("second emission step without a sample");

    // A beat that is not the last of its run is followed by the second step.
    a_first_beat_then_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !out_beat_next.last_of_run) |=> phase_reg)
        else $error("first beat of a pair not followed by the second step");

    // A pending sample exists only once a sample has been kept.
    a_pending_after_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> kept_valid_reg)
        else $error("pending sample without a kept sample");

    // An emitted beat never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit)
        else $error("result beat overwritten while stalled");

endmodule
